// ----- sv/dmhp_pkg.sv -----
// package for the dicom meta header parser: types, codes and vr tables
package dmhp_pkg;

	localparam int PREAMBLE_BYTES = 128;
	localparam int PREFIX_LEN = PREAMBLE_BYTES + 4;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_HEADER,
		PH_VALUE,
		PH_DONE
	} phase_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_OK     = 2'd2;
	localparam logic [1:0] KIND_FAIL   = 2'd3;

	localparam logic [2:0] FR_NONE      = 3'd0;
	localparam logic [2:0] FR_PREFIX    = 3'd1;
	localparam logic [2:0] FR_VR        = 3'd2;
	localparam logic [2:0] FR_TRUNCATED = 3'd3;
	localparam logic [2:0] FR_FIRST     = 3'd4;
	localparam logic [2:0] FR_INVALID   = 3'd5;

	localparam logic [4:0] VR_AE = 5'd0,  VR_AS = 5'd1,  VR_AT = 5'd2,  VR_CS = 5'd3;
	localparam logic [4:0] VR_DA = 5'd4,  VR_DS = 5'd5,  VR_DT = 5'd6,  VR_FD = 5'd7;
	localparam logic [4:0] VR_FL = 5'd8,  VR_IS = 5'd9,  VR_LO = 5'd10, VR_LT = 5'd11;
	localparam logic [4:0] VR_OB = 5'd12, VR_OD = 5'd13, VR_OF = 5'd14, VR_OL = 5'd15;
	localparam logic [4:0] VR_OW = 5'd16, VR_PN = 5'd17, VR_SH = 5'd18, VR_SL = 5'd19;
	localparam logic [4:0] VR_SQ = 5'd20, VR_SS = 5'd21, VR_ST = 5'd22, VR_TM = 5'd23;
	localparam logic [4:0] VR_UC = 5'd24, VR_UI = 5'd25, VR_UL = 5'd26, VR_UN = 5'd27;
	localparam logic [4:0] VR_UR = 5'd28, VR_US = 5'd29, VR_UT = 5'd30;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] tag_group;
		logic [15:0] tag_element;
		logic [4:0]  vr_code;
		logic [31:0] value_length;
		logic [7:0]  value_byte;
		logic        is_binary;
		logic        is_padding;
		logic        last_value_byte;
		logic [2:0]  fail_reason;
	} res_t;

	// returns {found, code}
	function automatic logic [5:0] vr_lookup(input logic [7:0] c1, input logic [7:0] c2);
		logic [15:0] p;
		logic [5:0] r;
		p = {c1, c2};
		case (p)
			"AE": r = {1'b1, VR_AE};
			"AS": r = {1'b1, VR_AS};
			"AT": r = {1'b1, VR_AT};
			"CS": r = {1'b1, VR_CS};
			"DA": r = {1'b1, VR_DA};
			"DS": r = {1'b1, VR_DS};
			"DT": r = {1'b1, VR_DT};
			"FD": r = {1'b1, VR_FD};
			"FL": r = {1'b1, VR_FL};
			"IS": r = {1'b1, VR_IS};
			"LO": r = {1'b1, VR_LO};
			"LT": r = {1'b1, VR_LT};
			"OB": r = {1'b1, VR_OB};
			"OD": r = {1'b1, VR_OD};
			"OF": r = {1'b1, VR_OF};
			"OL": r = {1'b1, VR_OL};
			"OW": r = {1'b1, VR_OW};
			"PN": r = {1'b1, VR_PN};
			"SH": r = {1'b1, VR_SH};
			"SL": r = {1'b1, VR_SL};
			"SQ": r = {1'b1, VR_SQ};
			"SS": r = {1'b1, VR_SS};
			"ST": r = {1'b1, VR_ST};
			"TM": r = {1'b1, VR_TM};
			"UC": r = {1'b1, VR_UC};
			"UI": r = {1'b1, VR_UI};
			"UL": r = {1'b1, VR_UL};
			"UN": r = {1'b1, VR_UN};
			"UR": r = {1'b1, VR_UR};
			"US": r = {1'b1, VR_US};
			"UT": r = {1'b1, VR_UT};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic vr_is_long(input logic [4:0] v);
		logic r;
		case (v)
			VR_OB, VR_OD, VR_OF, VR_OL, VR_OW, VR_SQ, VR_UC, VR_UN, VR_UR, VR_UT: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic vr_is_bin(input logic [4:0] v);
		logic r;
		case (v)
			VR_AT, VR_FD, VR_FL, VR_OB, VR_OD, VR_OF, VR_OL, VR_OW,
			VR_SL, VR_SQ, VR_SS, VR_UL, VR_UN, VR_US: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic vr_len_ok(input logic [4:0] v, input logic [31:0] len);
		logic r;
		case (v)
			VR_AE, VR_CS, VR_DS, VR_SH: r = (len <= 32'd16);
			VR_AS, VR_AT, VR_FL, VR_SL, VR_UL: r = (len == 32'd4);
			VR_DA: r = (len <= 32'd18);
			VR_DT: r = (len <= 32'd54);
			VR_FD: r = (len == 32'd8);
			VR_IS: r = (len <= 32'd12);
			VR_LO, VR_UI: r = (len <= 32'd64);
			VR_LT: r = (len <= 32'd10240);
			VR_ST: r = (len <= 32'd1024);
			VR_TM: r = (len <= 32'd28);
			VR_SS, VR_US: r = (len == 32'd2);
			VR_OD: r = (len <= 32'hFFFF_FFF8);
			VR_OF: r = (len <= 32'hFFFF_FFFC);
			VR_UC, VR_UR, VR_UT: r = (len <= 32'hFFFF_FFFE);
			default: r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/dicom_meta_header_parser.sv -----
// top level of the dicom meta header parser
//
// Input channel: one file byte per word (data_byte, end_of_file) on
// in_valid / in_stall. Output channel: one result word per transfer
// (kind, tag, vr, length, value byte, flags, fail reason) on
// out_valid / out_stall.
// Each accepted byte is decoded in the cycle it is taken and yields zero,
// one or two result words, written into a four-word output queue. The first
// result is offered on the output the cycle after the byte is accepted if
// the queue was empty. Throughput is one byte per cycle; the input stalls
// only while the queue holds more than two words, so a stalled receiver
// throttles the input once the queue fills and nothing is lost.
// After a finished or failed word all further bytes are taken and dropped
// until reset.
// Reset (arst_n low) puts the parser back at the start of the preamble and
// empties the queue.
module dicom_meta_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] tag_group,
	output logic [15:0] tag_element,
	output logic [4:0]  vr_code,
	output logic [31:0] value_length,
	output logic [7:0]  value_byte,
	output logic        is_binary,
	output logic        is_padding,
	output logic        last_value_byte,
	output logic [2:0]  fail_reason
);
	import dmhp_pkg::*;

	localparam logic [32:0] POS_MAX = '1;

	phase_t      phase_q, phase_d;
	logic [32:0] pos_q, pos_d;
	logic [33:0] stop_q, stop_d;
	logic [7:0]  hb_q [0:7];
	logic [7:0]  hb_d [0:7];
	logic [3:0]  hcnt_q, hcnt_d;
	logic [31:0] len_q, len_d;
	logic [31:0] rem_q, rem_d;
	logic [4:0]  vr_q, vr_d;
	logic        age_q, age_d;
	logic [31:0] glv_q, glv_d;
	logic        first_q, first_d;
	logic [2:0]  voff_q, voff_d;

	res_t        r0, r1;
	logic        v0, v1;
	res_t        fifo_q [0:3];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        acc, pop;

	logic [5:0]  look;
	logic [32:0] pos_n;
	logic        fin;
	logic        last;
	res_t        hdr_r, val_r;
	logic [31:0] hlen;

	assign acc = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign in_stall = (cnt_q > 3'd2);
	assign pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 33'd1;
	assign look = vr_lookup(hb_q[4], data_byte);
	assign last = (rem_q == 32'd1);

	function automatic res_t mk_end(input logic [1:0] k, input logic [2:0] fr);
		res_t r;
		r = '0;
		r.kind = k;
		r.fail_reason = fr;
		return r;
	endfunction

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		stop_d = stop_q;
		hb_d = hb_q;
		hcnt_d = hcnt_q;
		len_d = len_q;
		rem_d = rem_q;
		vr_d = vr_q;
		age_d = age_q;
		glv_d = glv_q;
		first_d = first_q;
		voff_d = voff_q;
		r0 = '0;
		r1 = '0;
		v0 = 1'b0;
		v1 = 1'b0;
		fin = 1'b0;
		hlen = len_q;
		hdr_r = '0;
		val_r = '0;
		if (acc && phase_q != PH_DONE) begin
			pos_d = pos_n;
			unique case (phase_q)
				PH_PREFIX: begin
					if (pos_q >= 33'(PREAMBLE_BYTES) && pos_q < 33'(PREFIX_LEN) &&
					    data_byte != 8'("DICM" >> (8 * (3 - (pos_q[1:0]))))) begin
						r0 = mk_end(KIND_FAIL, FR_PREFIX);
						v0 = 1'b1;
						phase_d = PH_DONE;
					end else if (pos_q >= 33'(PREFIX_LEN - 1)) begin
						phase_d = PH_HEADER;
						hcnt_d = 4'd0;
						len_d = '0;
						if (end_of_file) begin
							r0 = mk_end(KIND_FAIL, FR_TRUNCATED);
							v0 = 1'b1;
							phase_d = PH_DONE;
						end
					end else if (end_of_file) begin
						r0 = mk_end(KIND_FAIL, FR_PREFIX);
						v0 = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_HEADER: begin
					hcnt_d = hcnt_q + 4'd1;
					if (hcnt_q < 4'd8) begin
						hb_d[hcnt_q[2:0]] = data_byte;
					end else begin
						case (hcnt_q[1:0])
							2'd0: len_d[7:0] = data_byte;
							2'd1: len_d[15:8] = data_byte;
							2'd2: len_d[23:16] = data_byte;
							default: len_d[31:24] = data_byte;
						endcase
					end
					if (hcnt_q == 4'd5) begin
						vr_d = look[4:0];
					end
					if (hcnt_q == 4'd5 && !look[5]) begin
						vr_d = VR_AE;
						r0 = mk_end(KIND_FAIL, FR_VR);
						v0 = 1'b1;
						phase_d = PH_DONE;
					end else if ((hcnt_q == 4'd7 && !vr_is_long(vr_q)) || hcnt_q == 4'd11) begin
						if (hcnt_q == 4'd7) begin
							len_d = {16'd0, data_byte, hb_q[6]};
						end
						hlen = len_d;
						if (first_q && ({hb_q[1], hb_q[0]} != 16'h0002 ||
						    {hb_q[3], hb_q[2]} != 16'h0000 || vr_q != VR_UL ||
						    hlen != 32'd4)) begin
							r0 = mk_end(KIND_FAIL, FR_FIRST);
							v0 = 1'b1;
							phase_d = PH_DONE;
						end else if (!first_q && !vr_len_ok(vr_q, hlen)) begin
							r0 = mk_end(KIND_FAIL, FR_INVALID);
							v0 = 1'b1;
							phase_d = PH_DONE;
						end else begin
							hdr_r.kind = KIND_HEADER;
							hdr_r.tag_group = {hb_q[1], hb_q[0]};
							hdr_r.tag_element = {hb_q[3], hb_q[2]};
							hdr_r.vr_code = vr_q;
							hdr_r.value_length = hlen;
							hdr_r.is_binary = vr_is_bin(vr_q);
							r0 = hdr_r;
							v0 = 1'b1;
							rem_d = hlen;
							age_d = 1'b1;
							voff_d = 3'd0;
							if (hlen == 32'd0) begin
								fin = first_q ? (glv_q == 32'd0) : ({1'b0, pos_n} >= stop_q);
								if (first_q) begin
									stop_d = {1'b0, pos_n} + {2'b0, glv_q};
									first_d = 1'b0;
								end
								if (fin) begin
									r1 = mk_end(KIND_OK, FR_NONE);
									v1 = 1'b1;
									phase_d = PH_DONE;
								end else if (end_of_file) begin
									r1 = mk_end(KIND_FAIL, FR_TRUNCATED);
									v1 = 1'b1;
									phase_d = PH_DONE;
								end else begin
									hcnt_d = 4'd0;
									len_d = '0;
								end
							end else if (end_of_file) begin
								r1 = mk_end(KIND_FAIL, FR_TRUNCATED);
								v1 = 1'b1;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_VALUE;
							end
						end
					end else if (end_of_file) begin
						r0 = mk_end(KIND_FAIL, FR_TRUNCATED);
						v0 = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_VALUE: begin
					if (vr_q == VR_AS) begin
						if (voff_q < 3'd3) begin
							if (data_byte < "0" || data_byte > "9") age_d = 1'b0;
						end else if (data_byte != "D" && data_byte != "W" &&
						             data_byte != "M" && data_byte != "Y") begin
							age_d = 1'b0;
						end
					end
					if (first_q && voff_q < 3'd4) begin
						case (voff_q[1:0])
							2'd0: glv_d[7:0] = data_byte;
							2'd1: glv_d[15:8] = data_byte;
							2'd2: glv_d[23:16] = data_byte;
							default: glv_d[31:24] = data_byte;
						endcase
					end
					if (voff_q < 3'd4) voff_d = voff_q + 3'd1;
					val_r.kind = KIND_VALUE;
					val_r.tag_group = {hb_q[1], hb_q[0]};
					val_r.tag_element = {hb_q[3], hb_q[2]};
					val_r.vr_code = vr_q;
					val_r.value_length = len_q;
					val_r.value_byte = data_byte;
					val_r.is_binary = vr_is_bin(vr_q);
					val_r.is_padding = last && vr_q == VR_UI && data_byte == 8'd0;
					val_r.last_value_byte = last;
					r0 = val_r;
					v0 = 1'b1;
					rem_d = rem_q - 32'd1;
					if (last) begin
						if (vr_q == VR_AS && !age_d) begin
							r1 = mk_end(KIND_FAIL, FR_INVALID);
							v1 = 1'b1;
							phase_d = PH_DONE;
						end else begin
							fin = first_q ? (glv_d == 32'd0) : ({1'b0, pos_n} >= stop_q);
							if (first_q) begin
								stop_d = {1'b0, pos_n} + {2'b0, glv_d};
								first_d = 1'b0;
							end
							if (fin) begin
								r1 = mk_end(KIND_OK, FR_NONE);
								v1 = 1'b1;
								phase_d = PH_DONE;
							end else if (end_of_file) begin
								r1 = mk_end(KIND_FAIL, FR_TRUNCATED);
								v1 = 1'b1;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_HEADER;
								hcnt_d = 4'd0;
								len_d = '0;
							end
						end
					end else if (end_of_file) begin
						r1 = mk_end(KIND_FAIL, FR_TRUNCATED);
						v1 = 1'b1;
						phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q <= '0;
			stop_q <= '0;
			for (int i = 0; i < 8; i++) hb_q[i] <= '0;
			hcnt_q <= '0;
			len_q <= '0;
			rem_q <= '0;
			vr_q <= VR_AE;
			age_q <= 1'b1;
			glv_q <= '0;
			first_q <= 1'b1;
			voff_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			stop_q <= stop_d;
			hb_q <= hb_d;
			hcnt_q <= hcnt_d;
			len_q <= len_d;
			rem_q <= rem_d;
			vr_q <= vr_d;
			age_q <= age_d;
			glv_q <= glv_d;
			first_q <= first_d;
			voff_q <= voff_d;
		end
	end

	// output queue
	always_ff @(posedge clk) begin
		if (v0) fifo_q[wr_q] <= r0;
		if (v1) fifo_q[wr_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + {1'b0, v0} + {1'b0, v1};
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, v0} + {2'b0, v1} - {2'b0, pop};
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign kind = fifo_q[rd_q].kind;
	assign tag_group = fifo_q[rd_q].tag_group;
	assign tag_element = fifo_q[rd_q].tag_element;
	assign vr_code = fifo_q[rd_q].vr_code;
	assign value_length = fifo_q[rd_q].value_length;
	assign value_byte = fifo_q[rd_q].value_byte;
	assign is_binary = fifo_q[rd_q].is_binary;
	assign is_padding = fifo_q[rd_q].is_padding;
	assign last_value_byte = fifo_q[rd_q].last_value_byte;
	assign fail_reason = fifo_q[rd_q].fail_reason;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("output queue overflow");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> cnt_q <= 3'd2)
		else $error("word accepted without queue room");
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !pop) |=> cnt_q == $past(cnt_q))
		else $error("result produced after parse end");
	a_two_needs_one: assert property (@(posedge clk) disable iff (!arst_n)
		v1 |-> v0)
		else $error("second result without first");

endmodule

// ----- sim/dicom_meta_header_parser_tb.sv -----
// self-checking testbench for the dicom meta header parser
`timescale 1ns / 100ps

module dicom_meta_header_parser_tb;
	import dmhp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PAUSE_AT = 450;
	localparam longint unsigned POS_MAX = 64'h1_FFFF_FFFF;
	localparam string VR_NAMES = "AEASATCSDADSDTFDFLISLOLTOBODOFOLOWPNSHSLSQSSSTTMUCUIULUNURUSUT";
	localparam string DICM_MARK = "DICM";
	localparam string AGE_UNITS = "DWMY";
	localparam logic [30:0] LONG_VRS  = 31'h5911_F000;
	localparam logic [30:0] BIN_VRS   = 31'h2C39_F184;
	localparam logic [30:0] EXACT_VRS = 31'h2428_0186;
	localparam logic [31:0] LEN_LIMIT [31] = '{
		32'd16, 32'd4, 32'd4, 32'd16, 32'd18, 32'd16, 32'd54, 32'd8, 32'd4, 32'd12,
		32'd64, 32'd10240, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'hFFFF_FFFC, 32'hFFFF_FFFF,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16, 32'd4, 32'hFFFF_FFFF, 32'd2, 32'd1024,
		32'd28, 32'hFFFF_FFFE, 32'd64, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2,
		32'hFFFF_FFFE};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [15:0] tag_group;
	logic [15:0] tag_element;
	logic [4:0]  vr_code;
	logic [31:0] value_length;
	logic [7:0]  value_byte;
	logic        is_binary;
	logic        is_padding;
	logic        last_value_byte;
	logic [2:0]  fail_reason;

	// parser state as predicted
	phase_t          ph = PH_PREFIX;
	longint unsigned pos = 0;
	longint unsigned stop_pos = 0;
	logic [63:0]     hdr = '0;
	logic [31:0]     remaining = '0;
	logic [31:0]     cur_len = '0;
	logic [31:0]     glen = '0;
	logic [4:0]      cvr = '0;
	bit              age_ok = 1'b1;
	bit              first_elem = 1'b1;
	int              hcnt = 0;

	res_t expected_results [$];
	int   errors = 0;
	int   cycles = 0;
	int   bytes_sent = 0;
	int   words_checked = 0;
	int   send_idle = 15;
	int   recv_idle = 79;
	int   end_case = 0;

	dicom_meta_header_parser dut (.*);

	always #5 clk = ~clk;

	function automatic void push_result(logic [1:0] k, logic [7:0] vb, bit pad, bit last,
			logic [2:0] reason);
		res_t r;
		r = '0;
		r.kind = k;
		if (k == KIND_HEADER || k == KIND_VALUE) begin
			r.tag_group = hdr[15:0];
			r.tag_element = hdr[31:16];
			r.vr_code = cvr;
			r.value_length = cur_len;
			r.value_byte = vb;
			r.is_binary = BIN_VRS[cvr];
			r.is_padding = pad;
			r.last_value_byte = last;
		end
		r.fail_reason = reason;
		expected_results.push_back(r);
	endfunction

	function automatic void parse_fail(logic [2:0] reason);
		push_result(KIND_FAIL, 8'd0, 1'b0, 1'b0, reason);
		ph = PH_DONE;
	endfunction

	function automatic void start_header();
		ph = PH_HEADER;
		hcnt = 0;
		hdr = '0;
		cur_len = '0;
	endfunction

	function automatic void element_end(bit eof);
		if (first_elem) begin
			stop_pos = pos + glen;
			first_elem = 1'b0;
		end
		if (pos >= stop_pos) begin
			push_result(KIND_OK, 8'd0, 1'b0, 1'b0, FR_NONE);
			ph = PH_DONE;
		end else if (eof)
			parse_fail(FR_TRUNCATED);
		else
			start_header();
	endfunction

	function automatic void header_end(bit eof);
		bit ok;
		if (first_elem) begin
			ok = hdr[15:0] == 16'h0002 && hdr[31:16] == 16'h0000 && cvr == VR_UL
				&& cur_len == 32'd4;
			if (!ok) begin
				parse_fail(FR_FIRST);
				return;
			end
		end else begin
			ok = EXACT_VRS[cvr] ? cur_len == LEN_LIMIT[cvr] : cur_len <= LEN_LIMIT[cvr];
			if (!ok) begin
				parse_fail(FR_INVALID);
				return;
			end
		end
		push_result(KIND_HEADER, 8'd0, 1'b0, 1'b0, FR_NONE);
		remaining = cur_len;
		age_ok = 1'b1;
		if (cur_len == 0)
			element_end(eof);
		else if (eof)
			parse_fail(FR_TRUNCATED);
		else
			ph = PH_VALUE;
	endfunction

	function automatic void parse_byte(logic [7:0] b, bit eof);
		longint unsigned idx;
		int i;
		bit found;
		bit last;
		bit pad;
		logic [31:0] off;
		if (ph == PH_DONE)
			return;
		idx = pos;
		if (pos < POS_MAX)
			pos++;
		case (ph)
			PH_PREFIX: begin
				if (idx >= PREAMBLE_BYTES && idx < PREFIX_LEN
						&& b != DICM_MARK.getc(int'(idx - PREAMBLE_BYTES))) begin
					parse_fail(FR_PREFIX);
					return;
				end
				if (idx >= PREFIX_LEN - 1) begin
					start_header();
					if (eof)
						parse_fail(FR_TRUNCATED);
				end else if (eof)
					parse_fail(FR_PREFIX);
			end
			PH_HEADER: begin
				i = hcnt;
				if (i < 8)
					hdr[8*i +: 8] = b;
				else if (i < 12)
					cur_len[8*(i-8) +: 8] = b;
				hcnt = i + 1;
				if (i == 5) begin
					found = 1'b0;
					for (int v = 0; v < 31; v++)
						if (!found && VR_NAMES.getc(2*v) == hdr[39:32]
								&& VR_NAMES.getc(2*v+1) == hdr[47:40]) begin
							cvr = 5'(v);
							found = 1'b1;
						end
					if (!found) begin
						cvr = '0;
						parse_fail(FR_VR);
						return;
					end
				end
				if (i == 7 && !LONG_VRS[cvr]) begin
					cur_len = {16'd0, hdr[63:48]};
					header_end(eof);
				end else if (i == 11)
					header_end(eof);
				else if (eof)
					parse_fail(FR_TRUNCATED);
			end
			PH_VALUE: begin
				off = cur_len - remaining;
				last = remaining == 32'd1;
				pad = last && cvr == VR_UI && b == 8'd0;
				if (cvr == VR_AS) begin
					if (off < 3) begin
						if (b < "0" || b > "9")
							age_ok = 1'b0;
					end else if (b != "D" && b != "W" && b != "M" && b != "Y")
						age_ok = 1'b0;
				end
				if (first_elem && off < 4)
					glen[8*off +: 8] = b;
				push_result(KIND_VALUE, b, pad, last, FR_NONE);
				remaining--;
				if (last) begin
					if (cvr == VR_AS && !age_ok)
						parse_fail(FR_INVALID);
					else
						element_end(eof);
				end else if (eof)
					parse_fail(FR_TRUNCATED);
			end
			default: ;
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b, input bit eof);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		do @(posedge clk); while (in_stall);
		parse_byte(b, eof);
		bytes_sent++;
		if (bytes_sent < 300) begin
			send_idle = 15;
			recv_idle = 79;
		end else if (bytes_sent < 600) begin
			send_idle = 79;
			recv_idle = 15;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		if (bytes_sent == PAUSE_AT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (expected_results.size() != 0);
		end
	endtask

	// value mode: 0 well formed, 1 broken age string
	task automatic send_element(input logic [15:0] grp, input logic [15:0] elem,
			input logic [4:0] vr, input logic [31:0] len, input int mode, input int eof_at);
		logic [7:0] bytes [$];
		logic [7:0] b;
		bytes = '{grp[7:0], grp[15:8], elem[7:0], elem[15:8],
			VR_NAMES.getc(2*vr), VR_NAMES.getc(2*vr+1)};
		if (LONG_VRS[vr])
			bytes = {bytes, 8'($urandom), 8'($urandom), len[7:0], len[15:8], len[23:16],
				len[31:24]};
		else
			bytes = {bytes, len[7:0], len[15:8]};
		for (int k = 0; k < int'(len); k++) begin
			if (vr == VR_AS)
				b = k < 3 ? 8'("0" + $urandom_range(9)) : AGE_UNITS.getc($urandom_range(3));
			else if (vr == VR_UI)
				b = k == int'(len) - 1 && $urandom_range(1) ? 8'd0 : 8'("0" + $urandom_range(9));
			else
				b = 8'($urandom);
			if (mode == 1 && k == 3)
				b = "X";
			bytes.push_back(b);
		end
		foreach (bytes[k])
			send_word(bytes[k], k == eof_at);
	endtask

	task automatic send_raw(input string s);
		for (int k = 0; k < s.len(); k++)
			send_word(s.getc(k), 1'b0);
	endtask

	task automatic send_bytes(input logic [7:0] bs [$]);
		foreach (bs[k])
			send_word(bs[k], 1'b0);
	endtask

	function automatic logic [31:0] pick_len(logic [4:0] vr);
		if (EXACT_VRS[vr])
			return LEN_LIMIT[vr];
		if (LEN_LIMIT[vr] <= 64)
			return $urandom_range(9) == 0 ? LEN_LIMIT[vr] : $urandom_range(LEN_LIMIT[vr] < 10 ?
				LEN_LIMIT[vr] : 10);
		return $urandom_range(12);
	endfunction

	task automatic test_prefix_and_group_length();
		logic [31:0] gl;
		logic [7:0] first_hdr [$];
		gl = $urandom_range(1000, 1100);
		first_hdr = '{8'h02, 8'h00, 8'h00, 8'h00, "U", "L", 8'h04, 8'h00};
		for (int k = 0; k < PREAMBLE_BYTES; k++)
			send_word(k < 2 ? 8'(k * 255) : 8'($urandom), 1'b0);
		send_raw("DICM");
		send_bytes(first_hdr);
		for (int k = 0; k < 4; k++)
			send_word(gl[8*k +: 8], 1'b0);
	endtask

	task automatic test_every_vr();
		logic [31:0] len;
		for (int v = 0; v < 31; v++) begin
			case (v)
				VR_UI: len = 64;
				VR_DT: len = 54;
				VR_AE: len = 16;
				default: len = LONG_VRS[v] ? 0 : pick_len(5'(v));
			endcase
			send_element(v == 0 ? 16'h0000 : v == 1 ? 16'hFFFF : 16'h0002,
				v == 0 ? 16'hFFFF : 16'(v), 5'(v), len, 0, -1);
		end
		send_element(16'h0002, 16'h0010, VR_UI, 7, 0, -1);
	endtask

	task automatic test_random_elements();
		logic [4:0] vr;
		while (ph != PH_DONE && bytes_sent < 900) begin
			vr = 5'($urandom_range(30));
			send_element(16'($urandom), 16'($urandom), vr, pick_len(vr), 0, -1);
		end
	endtask

	task automatic test_termination();
		logic [7:0] bad_vr [$];
		end_case = $urandom_range(5);
		case (end_case)
			1: begin
				bad_vr = '{8'h08, 8'h00, 8'h10, 8'h00, "Q", "Q", 8'h02, 8'h00, "a", "b"};
				send_bytes(bad_vr);
			end
			2: send_element(16'h0008, 16'h0020, VR_US, 3, 0, -1);
			3: send_element(16'h0010, 16'h1010, VR_AS, 4, 1, -1);
			4: send_element(16'h0008, 16'h0030, VR_LO, 10, 0, $urandom_range(15));
			5: send_element(16'h0008, 16'h0040, VR_OB, 0, 0, 11);
			default: ;
		endcase
		while (ph != PH_DONE) begin
			send_element(16'($urandom), 16'($urandom), VR_OB, $urandom_range(12), 0, -1);
		end
	endtask

	task automatic test_ignored_after_end();
		for (int k = 0; k < 16; k++)
			send_word(8'($urandom), k == 15);
		in_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		out_stall <= $urandom_range(99) < recv_idle;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word, kind %0d", kind);
				errors++;
			end else begin
				e = expected_results.pop_front();
				words_checked++;
				check_field("kind", 32'(e.kind), 32'(kind));
				check_field("tag_group", 32'(e.tag_group), 32'(tag_group));
				check_field("tag_element", 32'(e.tag_element), 32'(tag_element));
				check_field("vr_code", 32'(e.vr_code), 32'(vr_code));
				check_field("value_length", e.value_length, value_length);
				check_field("value_byte", 32'(e.value_byte), 32'(value_byte));
				check_field("is_binary", 32'(e.is_binary), 32'(is_binary));
				check_field("is_padding", 32'(e.is_padding), 32'(is_padding));
				check_field("last_value_byte", 32'(e.last_value_byte),
					32'(last_value_byte));
				check_field("fail_reason", 32'(e.fail_reason), 32'(fail_reason));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dicom_meta_header_parser test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_prefix_and_group_length();
		test_every_vr();
		test_random_elements();
		test_termination();
		test_ignored_after_end();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result words never arrived", expected_results.size());
			errors++;
		end
		$display("covered %0d bytes, %0d result words, ending case %0d, %0d mismatches",
			bytes_sent, words_checked, end_case, errors);
		if (errors == 0)
			$display("dicom_meta_header_parser test passed");
		else
			$display("dicom_meta_header_parser test failed");
		$finish;
	end

endmodule

// ----- files.f -----
sv/dmhp_pkg.sv
sv/dicom_meta_header_parser.sv
sim/dicom_meta_header_parser_tb.sv
